// ===== hdl/sobel_edge_magnitude_rgb_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sem_pkg.sv =====
package sem_pkg;

    // Default geometry limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int FW_W  = 11;
    localparam int FH_W  = 13;
    localparam int CFG_W = 13;

    // Datapath widths: |g| <= 1020, g^2 sum < 2^21, 11-bit root
    localparam int GRAD_W     = 12;
    localparam int MAG_W      = 10;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RADIX_W    = 22;
    localparam int ROOT_W     = RADIX_W / 2;
    localparam int ROOT_STEPS = RADIX_W / 2;
    localparam int REM_W      = 14;
    localparam int STEP_W     = 4;

    localparam logic [FW_W-1:0] RESET_WIDTH  = 11'd1024;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd1024;
    localparam logic [CH_W-1:0] EDGE_MAX     = 8'd255;

    // Register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Sobel kernels, [row][column]
    localparam int KX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    localparam int KY [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

    typedef logic [2:0][2:0][CH_W-1:0] win_chan_t;

    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } win_mask_t;

endpackage

// ===== hdl/sem_line_store.sv =====
module sem_line_store #(
    parameter int DEPTH = sem_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    input  logic [sem_pkg::PIX_W-1:0] wr0_data,
    input  logic                     wr1_en,
    input  logic [AW-1:0]            wr1_addr,
    input  logic [sem_pkg::PIX_W-1:0] wr1_data,
    output logic [sem_pkg::PIX_W-1:0] q0,
    output logic [sem_pkg::PIX_W-1:0] q1
);
    import sem_pkg::*;

    logic [PIX_W-1:0] line0_mem [DEPTH];
    logic [PIX_W-1:0] line1_mem [DEPTH];
    logic [PIX_W-1:0] q0_reg;
    logic [PIX_W-1:0] q1_reg;

    // Read-first on the newest line, new pixel written to the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q0_reg             <= line0_mem[rd_addr];
            q1_reg             <= line1_mem[rd_addr];
            line0_mem[rd_addr] <= wr0_data;
        end
        if (wr1_en)
        begin
            line1_mem[wr1_addr] <= wr1_data;
        end
    end

    assign q0 = q0_reg;
    assign q1 = q1_reg;

endmodule

// ===== hdl/sem_lane.sv =====
module sem_lane (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  sem_pkg::win_chan_t       pix,
    input  sem_pkg::win_mask_t       mask,
    output logic                     done,
    output logic [sem_pkg::CH_W-1:0] edge_mag
);
    import sem_pkg::*;

    typedef enum logic [2:0] {L_IDLE, L_SQUARE, L_SUM, L_ROOT, L_ROUND} lane_state_t;

    lane_state_t         state_reg;
    logic [MAG_W-1:0]    ax_reg, ay_reg;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [RADIX_W-1:0]  rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;
    logic [CH_W-1:0]     edge_reg;

    logic signed [GRAD_W-1:0] gx, gy;
    logic [MAG_W-1:0]    ax_abs, ay_abs;
    logic [REM_W-1:0]    rem_sh, trial;
    logic                fits;
    logic [ROOT_W:0]     rounded;
    logic [SUM_W-1:0]    sum_sq;

    // Masked Sobel gradients
    always_comb
    begin
        gx = '0;
        gy = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (mask.row_ok[r] && mask.col_ok[c])
                begin
                    gx = gx + $signed(GRAD_W'(KX[r][c]))
                            * $signed({{(GRAD_W-CH_W){1'b0}}, pix[r][c]});
                    gy = gy + $signed(GRAD_W'(KY[r][c]))
                            * $signed({{(GRAD_W-CH_W){1'b0}}, pix[r][c]});
                end
            end
        end
    end

    assign ax_abs = MAG_W'(gx[GRAD_W-1] ? -gx : gx);
    assign ay_abs = MAG_W'(gy[GRAD_W-1] ? -gy : gy);
    assign sum_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // One root bit per cycle, restoring
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RADIX_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    // Round up when the remainder exceeds the floor root
    assign rounded = {1'b0, root_reg} + (ROOT_W+1)'(rem_reg > REM_W'(root_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        ax_reg    <= ax_abs;
                        ay_reg    <= ay_abs;
                        state_reg <= L_SQUARE;
                    end
                end
                L_SQUARE:
                begin
                    sqx_reg   <= ax_reg * ax_reg;
                    sqy_reg   <= ay_reg * ay_reg;
                    state_reg <= L_SUM;
                end
                L_SUM:
                begin
                    rad_reg   <= RADIX_W'(sum_sq);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= L_ROOT;
                end
                L_ROOT:
                begin
                    rad_reg  <= {rad_reg[RADIX_W-3:0], 2'b00};
                    rem_reg  <= fits ? rem_sh - trial : rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], fits};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    begin
                        state_reg <= L_ROUND;
                    end
                end
                L_ROUND:
                begin
                    edge_reg  <= (rounded > (ROOT_W+1)'(EDGE_MAX)) ? EDGE_MAX
                                                                  : rounded[CH_W-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign edge_mag = edge_reg;

endmodule

// ===== hdl/sobel_edge_magnitude_rgb.sv =====
// Channel   Handshake            Payload
// in        in_valid/in_ready    pixel_red, pixel_green, pixel_blue, drain
// out       out_valid/out_ready  edge_red, edge_green, edge_blue, frame_done
// cfg       cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
// One item at a time: an item that yields a result passes the window shift, the lane start, the
// 11-step bit-serial square root in each lane and the merge into the output register; the next
// transfer can follow once the merge is done.
// An item that yields no result only passes the line store read and window shift.
// Reset (async, active low) clears counters, window, control and config to defaults.
// A stalled output holds its result; the next item is accepted meanwhile and
// waits in its lane until the output register frees.
`include "sobel_edge_magnitude_rgb_defines.svh"

module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sem_pkg::CH_W-1:0]  pixel_red,
    input  logic [sem_pkg::CH_W-1:0]  pixel_green,
    input  logic [sem_pkg::CH_W-1:0]  pixel_blue,
    input  logic                      drain,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sem_pkg::CH_W-1:0]  edge_red,
    output logic [sem_pkg::CH_W-1:0]  edge_green,
    output logic [sem_pkg::CH_W-1:0]  edge_blue,
    output logic                      frame_done,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [sem_pkg::CFG_W-1:0] cfg_data
);
    import sem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = COL_W + 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW    = ROW_W + 1;

    typedef enum logic [2:0] {T_IDLE, T_WIN, T_START, T_RUN, T_MERGE} top_state_t;

    top_state_t          state_reg;
    logic [FW_W-1:0]     fw_reg;
    logic [FH_W-1:0]     fh_reg;
    logic [COL_W-1:0]    in_col_reg, out_col_reg, col_reg;
    logic [1:0]          in_row_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [PIX_W-1:0]    x_reg;
    logic                emit_reg, fdone_reg;
    win_mask_t           mask_reg;
    logic [2:0][2:0][PIX_W-1:0] window_reg;
    logic                out_valid_reg, frame_done_reg;
    logic [CH_W-1:0]     edge_red_reg, edge_green_reg, edge_blue_reg;

    logic [WW-1:0]       eff_w, in_col_inc, out_col_inc;
    logic [HW-1:0]       eff_h, out_row_inc;
    logic                in_wrap, emit, last_col, last_row, fdone, accept;
    logic [PIX_W-1:0]    x, tap1, tap2;
    win_mask_t           mask;
    logic [2:0]          lane_done;
    win_chan_t           lane_pix [3];
    logic [CH_W-1:0]     lane_edge [3];

    // Effective frame size: zero counts as one, clamp to the maximum
    always_comb
    begin
        if (fw_reg == '0)
            eff_w = WW'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(fw_reg);
        if (fh_reg == '0)
            eff_h = HW'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(fh_reg);
    end

    // Position bookkeeping for the item being accepted
    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == T_IDLE);
    assign x           = drain ? '0 : {pixel_red, pixel_green, pixel_blue};
    assign in_col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign in_wrap     = in_col_inc >= eff_w;
    assign emit        = (in_row_reg == 2'd2) || (in_row_reg == 2'd1 && in_col_reg != '0);
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;
    assign last_col    = out_col_inc >= eff_w;
    assign last_row    = out_row_inc >= eff_h;
    assign fdone       = last_col && last_row;
    assign mask.row_ok = {!last_row, 1'b1, out_row_reg != '0};
    assign mask.col_ok = {!last_col, 1'b1, out_col_reg != '0};

    // Two line delays
    sem_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (in_col_reg),
        .wr0_data (x),
        .wr1_en   (state_reg == T_WIN),
        .wr1_addr (col_reg),
        .wr1_data (tap1),
        .q0       (tap1),
        .q1       (tap2)
    );

    // One lane per color channel, red first
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lane_pix[g][r][c] = window_reg[r][c][CH_W*(2-g) +: CH_W];
                end
            end
        end

        sem_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (state_reg == T_START),
            .pix      (lane_pix[g]),
            .mask     (mask_reg),
            .done     (lane_done[g]),
            .edge_mag (lane_edge[g])
        );
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= RESET_WIDTH;
            fh_reg <= RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                CFG_IDX_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                default:        fw_reg <= fw_reg;
            endcase
        end
    end

    // Sequencer, counters, window and merged output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg      <= x;
                        col_reg    <= in_col_reg;
                        emit_reg   <= emit;
                        mask_reg   <= mask;
                        fdone_reg  <= fdone;
                        in_col_reg <= in_wrap ? '0 : in_col_inc[COL_W-1:0];
                        if (in_wrap && in_row_reg != 2'd2)
                            in_row_reg <= in_row_reg + 2'd1;
                        if (emit)
                        begin
                            if (fdone)
                            begin
                                in_col_reg  <= '0;
                                in_row_reg  <= '0;
                                out_col_reg <= '0;
                                out_row_reg <= '0;
                            end
                            else if (last_col)
                            begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_inc[ROW_W-1:0];
                            end
                            else
                            begin
                                out_col_reg <= out_col_inc[COL_W-1:0];
                            end
                        end
                        state_reg <= T_WIN;
                    end
                end
                T_WIN:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        window_reg[r][0] <= window_reg[r][1];
                        window_reg[r][1] <= window_reg[r][2];
                    end
                    window_reg[0][2] <= tap2;
                    window_reg[1][2] <= tap1;
                    window_reg[2][2] <= x_reg;
                    state_reg <= emit_reg ? T_START : T_IDLE;
                end
                T_START:
                begin
                    state_reg <= T_RUN;
                end
                T_RUN:
                begin
                    if (lane_done[0])
                        state_reg <= T_MERGE;
                end
                T_MERGE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        edge_red_reg   <= lane_edge[0];
                        edge_green_reg <= lane_edge[1];
                        edge_blue_reg  <= lane_edge[2];
                        frame_done_reg <= fdone_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_red   = edge_red_reg;
    assign edge_green = edge_green_reg;
    assign edge_blue  = edge_blue_reg;
    assign frame_done = frame_done_reg;

    `SEM_ASSERT_NOW(a_lanes_lockstep, lane_done[0], lane_done[1] && lane_done[2], "lanes out of step")
    `SEM_ASSERT_NEXT(a_one_item, accept, !in_ready, "second item taken while busy")
    `SEM_ASSERT_NEXT(a_merge_load, (state_reg == T_MERGE) && (!out_valid_reg || out_ready), out_valid, "merged result not presented")

endmodule

// ===== bench/sobel_checker.sv =====
module sobel_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [sem_pkg::CH_W-1:0]  pixel_red,
    input  logic [sem_pkg::CH_W-1:0]  pixel_green,
    input  logic [sem_pkg::CH_W-1:0]  pixel_blue,
    input  logic                      drain,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [sem_pkg::CH_W-1:0]  edge_red,
    input  logic [sem_pkg::CH_W-1:0]  edge_green,
    input  logic [sem_pkg::CH_W-1:0]  edge_blue,
    input  logic                      frame_done,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [sem_pkg::CFG_W-1:0] cfg_data,
    output int                        pending,
    output int                        errors,
    output int                        edges_seen,
    output int                        frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int LINE = DEF_MAX_WIDTH;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } edge_pix_t;

    edge_pix_t expected_edges[$];

    // shadow of the block's geometry and stream position
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] line_mem [0:2*LINE-1];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      in_col, in_row, out_col, out_row;

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return height_reg;
    endfunction

    // rounded, clamped gradient magnitude of one channel
    function automatic logic [CH_W-1:0] channel_mag(int sh, logic [2:0] rok, logic [2:0] cok);
        int gx, gy, v;
        int unsigned s, root;
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (rok[r] && cok[c])
                begin
                    v = win[r][c][sh +: CH_W];
                    gx += KX[r][c] * v;
                    gy += KY[r][c] * v;
                end
        s = gx * gx + gy * gy;
        root = 0;
        for (int b = 11; b >= 0; b--)
            if ((root | (1 << b)) * (root | (1 << b)) <= s)
                root |= (1 << b);
        if (s > root * root + root)
            root++;
        return (root > 255) ? EDGE_MAX : root[CH_W-1:0];
    endfunction

    task automatic predict_pixel(logic [PIX_W-1:0] px);
        int unsigned w, h, col;
        logic [PIX_W-1:0] tap1, tap2;
        logic [PIX_W-1:0] fresh [3];
        logic emit, last_col;
        logic [2:0] rok, cok;
        edge_pix_t e;
        w = eff_width();
        h = eff_height();
        col = (in_col < LINE) ? in_col : LINE - 1;
        tap1 = line_mem[col];
        tap2 = line_mem[LINE + col];
        line_mem[LINE + col] = tap1;
        line_mem[col] = px;
        fresh[0] = tap2;
        fresh[1] = tap1;
        fresh[2] = px;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = fresh[r];
        end
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            in_row++;
        end
        else
            in_col++;
        if (!emit)
            return;
        rok = {out_row + 1 < h, 1'b1, out_row > 0};
        cok = {out_col + 1 < w, 1'b1, out_col > 0};
        last_col = (out_col + 1 >= w);
        e.red   = channel_mag(16, rok, cok);
        e.green = channel_mag(8, rok, cok);
        e.blue  = channel_mag(0, rok, cok);
        e.last  = last_col && (out_row + 1 >= h);
        expected_edges.push_back(e);
        if (e.last)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        else if (last_col)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
    endtask

    task automatic report(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        edges_seen = 0;
        frames_seen = 0;
        pending = 0;
        width_reg = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        for (int i = 0; i < 2 * LINE; i++)
            line_mem[i] = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    end

    // watch config writes and both channels
    always @(posedge clk)
    begin
        edge_pix_t e;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_IDX_WIDTH)
                    width_reg = cfg_data[FW_W-1:0];
                else
                    height_reg = cfg_data[FH_W-1:0];
            end
            if (in_valid && in_ready)
                predict_pixel(drain ? '0 : {pixel_red, pixel_green, pixel_blue});
            if (out_valid && out_ready)
            begin
                edges_seen++;
                if (frame_done)
                    frames_seen++;
                if (expected_edges.size() == 0)
                begin
                    $display("[%0t] output transfer with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    e = expected_edges.pop_front();
                    if (edge_red !== e.red)     report("edge_red", edge_red, e.red);
                    if (edge_green !== e.green) report("edge_green", edge_green, e.green);
                    if (edge_blue !== e.blue)   report("edge_blue", edge_blue, e.blue);
                    if (frame_done !== e.last)  report("frame_done", frame_done, e.last);
                end
            end
        end
        pending = expected_edges.size();
    end
endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 30;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CH_W-1:0]   pixel_red, pixel_green, pixel_blue;
    logic              drain;
    logic              out_valid;
    logic              out_ready;
    logic [CH_W-1:0]   edge_red, edge_green, edge_blue;
    logic              frame_done;
    logic              cfg_write;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int pending, errors, edges_seen, frames_seen;
    int items_sent;
    int frames_sent;
    int cycles;
    bit steady;

    sobel_edge_magnitude_rgb i_dut (.*);

    sobel_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side back-pressure
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 37);

    task automatic send_item(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b, logic d);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_red   <= r;
        pixel_green <= g;
        pixel_blue  <= b;
        drain       <= d;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // wait out every expected result plus the no-result tail
    task automatic drain_wait();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] rand_chan(int style);
        if (style == 1)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return CH_W'($urandom_range(0, 255));
    endfunction

    // one full frame: pixels, sparse interior drains, then the closing drains
    task automatic run_frame(int unsigned wv, int unsigned hv);
        int unsigned w, h;
        int style;
        drain_wait();
        write_reg(CFG_IDX_WIDTH, wv);
        write_reg(CFG_IDX_HEIGHT, hv);
        w = (wv == 0) ? 1 : (wv > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : wv;
        h = (hv == 0) ? 1 : (hv > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : hv;
        style = $urandom_range(0, 3);
        for (int i = 0; i < w * h; i++)
            send_item(rand_chan(style), rand_chan(style), rand_chan(style),
                      $urandom_range(0, 99) < 8);
        for (int i = 0; i <= w; i++)
            send_item(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                      CH_W'($urandom_range(0, 255)), 1'b1);
        frames_sent++;
    endtask

    initial
    begin
        in_valid    = 1'b0;
        pixel_red   = '0;
        pixel_green = '0;
        pixel_blue  = '0;
        drain       = 1'b0;
        out_ready   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_IDX_WIDTH;
        cfg_data    = '0;
        steady      = 1'b0;
        items_sent  = 0;
        frames_sent = 0;
        rst_n       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 3x3 frame with full-scale steps and an interior drain
        write_reg(CFG_IDX_WIDTH, 3);
        write_reg(CFG_IDX_HEIGHT, 3);
        send_item(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_item(8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(8'hFF, 8'hFF, 8'h00, 1'b0);
        send_item(8'h00, 8'h00, 8'hFF, 1'b0);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(8'h55, 8'hAA, 8'h01, 1'b0);
        send_item(8'hFF, 8'h00, 8'h00, 1'b0);
        send_item(8'h80, 8'h7F, 8'hFE, 1'b0);
        send_item(8'h00, 8'hFF, 8'hFF, 1'b0);
        repeat (4) send_item(8'h00, 8'h00, 8'h00, 1'b1);
        frames_sent++;
        // zero registers count as 1x1
        drain_wait();
        write_reg(CFG_IDX_WIDTH, 0);
        write_reg(CFG_IDX_HEIGHT, 0);
        send_item(8'hFF, 8'h00, 8'hAA, 1'b0);
        repeat (2) send_item(8'h00, 8'h00, 8'h00, 1'b1);
        frames_sent++;
        // hold until every result is out
        drain_wait();

        // random small frames, one stretch without idling
        while (items_sent < 2000)
        begin
            steady = (frames_sent >= 20 && frames_sent < 30);
            run_frame(($urandom_range(0, 9) < 8) ? $urandom_range(1, 16)
                                                  : $urandom_range(0, 40),
                      $urandom_range(0, 10));
        end
        steady = 1'b0;

        drain_wait();
        $display("%0d items in %0d frames (widths 0..40, heights 0..10, zero sizes as one)",
                 items_sent, frames_sent);
        $display("%0d edge pixels and %0d frame ends checked", edges_seen, frames_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_line_store.sv
hdl/sem_lane.sv
hdl/sobel_edge_magnitude_rgb.sv
bench/sobel_checker.sv
bench/tb.sv
